FILE: sv/dependency_list_parser_defines.svh
// Assertion macros shared by the dependency list parser modules.
`ifndef DEPENDENCY_LIST_PARSER_DEFINES_SVH
`define DEPENDENCY_LIST_PARSER_DEFINES_SVH

`ifndef SYNTH
// Checked while out of reset, sampled on the rising edge of aclk.
`define DLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Checked on every edge, reset included.
`define DLP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define DLP_ASSERT(lbl, prop, msg)
`define DLP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: sv/dlp_pkg.sv
// Types and constants shared by the dependency list parser.
package dlp_pkg;

    localparam logic [3:0]  MAX_ENTRIES  = 4'd8;
    localparam logic [13:0] MAX_RESPONSE = 14'd8192;
    localparam int          OUT_DEPTH    = 4;

    typedef enum logic [2:0] {
        KIND_COUNT = 3'd0,
        KIND_ENTRY = 3'd1,
        KIND_NAME  = 3'd2,
        KIND_END   = 3'd3,
        KIND_ERROR = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  entry_index;
        logic [31:0] entry_count;
        logic [7:0]  found_flag;
        logic [31:0] first_id;
        logic [31:0] second_id;
        logic [31:0] third_id;
        logic [6:0]  name_length;
        logic [7:0]  name_char;
        logic        last_result;
    } res_t;

    // Results produced by one accepted byte: n is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage

FILE: sv/dlp_parser.sv
// Byte-wise response parser: state update and result formation per word.
`include "dependency_list_parser_defines.svh"

module dlp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  logic [7:0]          byte_value,
    input  logic [13:0]         response_length,
    input  logic                last_byte,
    input  logic [6:0]          name_limit,
    output dlp_pkg::push_t      push
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_COUNT  = 3'd1,
        PH_START  = 3'd2,
        PH_ID0    = 3'd3,
        PH_ID1    = 3'd4,
        PH_ID2    = 3'd5,
        PH_LEN    = 3'd6,
        PH_NAME   = 3'd7
    } phase_t;

    logic [13:0] offset_reg,    offset_next;
    phase_t      phase_reg,     phase_next;
    logic [31:0] shift_reg,     shift_next;
    logic [1:0]  seen_reg,      seen_next;
    logic [31:0] count_reg,     count_next;
    logic [3:0]  entry_reg,     entry_next;
    logic [7:0]  found_reg,     found_next;
    logic [31:0] id0_reg,       id0_next;
    logic [31:0] id1_reg,       id1_next;
    logic [31:0] id2_reg,       id2_next;
    logic [6:0]  remain_reg,    remain_next;
    logic        stopped_reg,   stopped_next;
    logic [6:0]  hlen_reg,      hlen_next;

    logic [13:0] len_c;
    logic [31:0] shifted;
    logic        field_done;
    logic [6:0]  clamped;
    logic [6:0]  remain_dec;
    logic        emit_a;
    dlp_pkg::res_t res_a;
    dlp_pkg::res_t res_b;

    function automatic dlp_pkg::res_t make_res(
        input dlp_pkg::kind_t k, input logic [3:0] ent, input logic [31:0] cnt,
        input logic [7:0] fnd, input logic [31:0] i0, input logic [31:0] i1,
        input logic [31:0] i2, input logic [6:0] ln, input logic [7:0] ch);
        dlp_pkg::res_t r;
        r = '0;
        r.kind = k;
        if (k != dlp_pkg::KIND_ERROR) begin
            r.entry_index = ent[2:0];
            r.entry_count = cnt;
        end
        if (k == dlp_pkg::KIND_ENTRY || k == dlp_pkg::KIND_NAME) begin
            r.found_flag  = fnd;
            r.first_id    = i0;
            r.second_id   = i1;
            r.third_id    = i2;
            r.name_length = ln;
        end
        if (k == dlp_pkg::KIND_NAME) begin
            r.name_char = ch;
        end
        return r;
    endfunction

    assign len_c      = (response_length > dlp_pkg::MAX_RESPONSE) ?
                        dlp_pkg::MAX_RESPONSE : response_length;
    assign shifted    = {shift_reg[23:0], byte_value};
    assign field_done = (seen_reg == 2'd3);
    assign clamped    = (shifted > {25'd0, name_limit}) ? name_limit : shifted[6:0];
    assign remain_dec = remain_reg - 7'd1;

    always_comb begin
        offset_next  = offset_reg;
        phase_next   = phase_reg;
        shift_next   = shift_reg;
        seen_next    = seen_reg;
        count_next   = count_reg;
        entry_next   = entry_reg;
        found_next   = found_reg;
        id0_next     = id0_reg;
        id1_next     = id1_reg;
        id2_next     = id2_reg;
        remain_next  = remain_reg;
        stopped_next = stopped_reg;
        hlen_next    = hlen_reg;
        emit_a       = 1'b0;
        res_a        = '0;
        res_b        = '0;
        push         = '0;

        if (!stopped_reg && offset_reg < len_c) begin
            case (phase_reg)
                PH_HEADER: begin
                    if (offset_reg >= 14'd27) begin
                        phase_next = PH_COUNT;
                        shift_next = '0;
                        seen_next  = '0;
                    end
                end
                PH_COUNT: begin
                    shift_next = shifted;
                    if (field_done) begin
                        seen_next  = '0;
                        count_next = shifted;
                        phase_next = PH_START;
                        emit_a     = 1'b1;
                        res_a      = make_res(dlp_pkg::KIND_COUNT, entry_reg, shifted,
                                              '0, '0, '0, '0, '0, '0);
                    end else begin
                        seen_next = seen_reg + 2'd1;
                    end
                end
                PH_START: begin
                    if ({28'd0, entry_reg} < count_reg &&
                        entry_reg < dlp_pkg::MAX_ENTRIES &&
                        ({1'b0, offset_reg} + 15'd13) < {1'b0, len_c}) begin
                        found_next = byte_value;
                        id0_next   = '0;
                        id1_next   = '0;
                        id2_next   = '0;
                        hlen_next  = '0;
                        shift_next = '0;
                        seen_next  = '0;
                        phase_next = PH_ID0;
                    end else begin
                        stopped_next = 1'b1;
                    end
                end
                PH_NAME: begin
                    emit_a      = 1'b1;
                    res_a       = make_res(dlp_pkg::KIND_NAME, entry_reg, count_reg,
                                           found_reg, id0_reg, id1_reg, id2_reg,
                                           hlen_reg, byte_value);
                    remain_next = remain_dec;
                    if (remain_dec == 7'd0) begin
                        entry_next = entry_reg + 4'd1;
                        phase_next = PH_START;
                    end
                end
                default: begin
                    // three ids then the name length, all big-endian words
                    shift_next = shifted;
                    if (field_done) begin
                        seen_next  = '0;
                        shift_next = '0;
                        case (phase_reg)
                            PH_ID0: id0_next = shifted;
                            PH_ID1: id1_next = shifted;
                            PH_ID2: id2_next = shifted;
                            default: begin
                                hlen_next = clamped;
                                emit_a    = 1'b1;
                                res_a     = make_res(dlp_pkg::KIND_ENTRY, entry_reg,
                                                     count_reg, found_reg, id0_reg,
                                                     id1_reg, id2_reg, clamped, '0);
                            end
                        endcase
                        if (phase_reg == PH_LEN) begin
                            if (clamped == 7'd0) begin
                                entry_next = entry_reg + 4'd1;
                                phase_next = PH_START;
                            end else begin
                                remain_next = clamped;
                                phase_next  = PH_NAME;
                            end
                        end else begin
                            phase_next = phase_t'(phase_reg + 3'd1);
                        end
                    end else begin
                        seen_next = seen_reg + 2'd1;
                    end
                end
            endcase
        end

        if (last_byte) begin
            if (phase_next inside {PH_START, PH_ID0, PH_ID1, PH_ID2, PH_LEN, PH_NAME}) begin
                res_b = make_res(dlp_pkg::KIND_END, entry_next, count_next,
                                 '0, '0, '0, '0, '0, '0);
            end else begin
                res_b = make_res(dlp_pkg::KIND_ERROR, entry_next, count_next,
                                 '0, '0, '0, '0, '0, '0);
            end
            res_b.last_result = 1'b1;
            offset_next  = '0;
            phase_next   = PH_HEADER;
            shift_next   = '0;
            seen_next    = '0;
            count_next   = '0;
            entry_next   = '0;
            found_next   = '0;
            id0_next     = '0;
            id1_next     = '0;
            id2_next     = '0;
            remain_next  = '0;
            stopped_next = 1'b0;
            hlen_next    = '0;
        end else if (offset_reg != 14'h3fff) begin
            offset_next = offset_reg + 14'd1;
        end

        if (in_accept) begin
            if (emit_a && last_byte) begin
                push.n  = 2'd2;
                push.r0 = res_a;
                push.r1 = res_b;
            end else if (emit_a) begin
                push.n  = 2'd1;
                push.r0 = res_a;
                push.r0.last_result = 1'b1;
            end else if (last_byte) begin
                push.n  = 2'd1;
                push.r0 = res_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg  <= '0;
            phase_reg   <= PH_HEADER;
            shift_reg   <= '0;
            seen_reg    <= '0;
            count_reg   <= '0;
            entry_reg   <= '0;
            found_reg   <= '0;
            id0_reg     <= '0;
            id1_reg     <= '0;
            id2_reg     <= '0;
            remain_reg  <= '0;
            stopped_reg <= 1'b0;
            hlen_reg    <= '0;
        end else if (in_accept) begin
            offset_reg  <= offset_next;
            phase_reg   <= phase_next;
            shift_reg   <= shift_next;
            seen_reg    <= seen_next;
            count_reg   <= count_next;
            entry_reg   <= entry_next;
            found_reg   <= found_next;
            id0_reg     <= id0_next;
            id1_reg     <= id1_next;
            id2_reg     <= id2_next;
            remain_reg  <= remain_next;
            stopped_reg <= stopped_next;
            hlen_reg    <= hlen_next;
        end
    end

    `DLP_ASSERT(a_name_left, (phase_reg == PH_NAME) |-> (remain_reg != 7'd0), "name phase with nothing left")
    `DLP_ASSERT(a_stop_holds, (stopped_reg && !(in_accept && last_byte)) |=> stopped_reg, "stop flag dropped mid-response")
    `DLP_ASSERT(a_pair_ends, (push.n == 2'd2) |-> (push.r1.last_result && !push.r0.last_result), "bad last flag on result pair")

endmodule

FILE: sv/dlp_out_fifo.sv
// Result queue taking up to two words per cycle and giving one.
`include "dependency_list_parser_defines.svh"

module dlp_out_fifo #(
    parameter int DEPTH = dlp_pkg::OUT_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  dlp_pkg::push_t  push,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output dlp_pkg::res_t   out_res
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dlp_pkg::res_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [PW-1:0] wr_ptr_b;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_res   = mem_reg[rd_ptr_reg];
    assign in_ready  = (count_reg <= CW'(DEPTH - 2));
    assign wr_ptr_b  = ptr_inc(wr_ptr_reg);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        case (push.n)
            2'd1:    wr_ptr_next = wr_ptr_b;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_b);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.n) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem_reg[wr_ptr_b] <= push.r1;
        end
    end

    `DLP_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "result queue overfilled")

endmodule

FILE: sv/dependency_list_parser.sv
// Top level of the dependency list response parser.
// Usage:
//   s_* channel: one response byte per word, with the response length and a
//   last-byte flag; bytes are taken whenever s_ready is high.
//   m_* channel: result words (count, entry record, name byte, end marker or
//   short-response error); m_last_result marks the final word of a byte.
//   cfg_* channel: writes the name length limit; always ready, and only to
//   be written while the block is idle.
// Result path: a byte's words are written into the result queue as it is taken.
// Throughput: one byte per cycle. A byte yields at most two words; the
//   result queue of OUT_DEPTH words admits a byte while at least two places
//   are free, so with m_ready held high s_ready stays high, bar the odd
//   bubble after a byte that made two words.
// Reset (aresetn low, synchronous): parser back to the header, queue empty,
//   name limit back to 127.
// Receiver stall: words wait in the queue, s_ready drops once it has fewer
//   than two free places, and no word is lost or repeated.
`include "dependency_list_parser_defines.svh"

module dependency_list_parser #(
    parameter int OUT_DEPTH = dlp_pkg::OUT_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic [13:0] s_response_length,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [2:0]  m_entry_index,
    output logic [31:0] m_entry_count,
    output logic [7:0]  m_found_flag,
    output logic [31:0] m_first_id,
    output logic [31:0] m_second_id,
    output logic [31:0] m_third_id,
    output logic [6:0]  m_name_length,
    output logic [7:0]  m_name_char,
    output logic        m_last_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_name_limit
);

    logic [6:0]     name_limit_reg;
    logic           s_accept;
    dlp_pkg::push_t push;
    dlp_pkg::res_t  head;

    // config register: taken on any cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_limit_reg <= 7'd127;
        end else if (cfg_valid && cfg_ready) begin
            name_limit_reg <= cfg_name_limit;
        end
    end

    assign s_accept = s_valid && s_ready;

    dlp_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (s_accept),
        .byte_value      (s_byte_value),
        .response_length (s_response_length),
        .last_byte       (s_last_byte),
        .name_limit      (name_limit_reg),
        .push            (push)
    );

    dlp_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (head)
    );

    // unpack the head of the queue
    assign m_kind        = head.kind;
    assign m_entry_index = head.entry_index;
    assign m_entry_count = head.entry_count;
    assign m_found_flag  = head.found_flag;
    assign m_first_id    = head.first_id;
    assign m_second_id   = head.second_id;
    assign m_third_id    = head.third_id;
    assign m_name_length = head.name_length;
    assign m_name_char   = head.name_char;
    assign m_last_result = head.last_result;

    // end and error words always close out the byte that caused them
    `DLP_ASSERT(a_end_is_last, (m_valid && (m_kind == dlp_pkg::KIND_END || m_kind == dlp_pkg::KIND_ERROR)) |-> m_last_result, "end word not flagged last")

endmodule

FILE: sim/dependency_list_parser_test.sv
// Self-checking testbench for the dependency list response parser.
module dependency_list_parser_test;

    // Generous ceiling: every word under the longest receiver stall, several times over.
    localparam int CYCLE_LIMIT   = 600000;
    // Bytes sent over the whole run; the random test tops up to this.
    localparam int ITEM_TARGET   = 1100;
    // Result words are queued as the byte is taken; this settle margin is plenty.
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 10;

    // Parser phases as the predictor tracks them.
    typedef enum logic [2:0] {
        PH_HEADER, PH_COUNT, PH_START, PH_ID0, PH_ID1, PH_ID2, PH_LEN, PH_NAME
    } parse_phase_t;

    logic        aclk              = 1'b0;
    logic        aresetn           = 1'b0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value      = '0;
    logic [13:0] s_response_length = '0;
    logic        s_last_byte       = 1'b0;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic [2:0]  m_kind;
    logic [2:0]  m_entry_index;
    logic [31:0] m_entry_count;
    logic [7:0]  m_found_flag;
    logic [31:0] m_first_id;
    logic [31:0] m_second_id;
    logic [31:0] m_third_id;
    logic [6:0]  m_name_length;
    logic [7:0]  m_name_char;
    logic        m_last_result;
    logic        cfg_valid         = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_name_limit    = '0;

    dependency_list_parser dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_byte_value      (s_byte_value),
        .s_response_length (s_response_length),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_entry_index     (m_entry_index),
        .m_entry_count     (m_entry_count),
        .m_found_flag      (m_found_flag),
        .m_first_id        (m_first_id),
        .m_second_id       (m_second_id),
        .m_third_id        (m_third_id),
        .m_name_length     (m_name_length),
        .m_name_char       (m_name_char),
        .m_last_result     (m_last_result),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_name_limit    (cfg_name_limit)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the parser and its name limit.
    // ------------------------------------------------------------------
    logic [13:0]  rx_offset;
    parse_phase_t rx_phase;
    logic [31:0]  field_acc;
    logic [1:0]   acc_bytes;
    logic [31:0]  list_count;
    logic [3:0]   entry_no;
    logic [7:0]   entry_found;
    logic [31:0]  entry_ids [3];
    logic [6:0]   entry_len;
    logic [6:0]   name_left;
    logic         list_stopped;
    logic [6:0]   name_limit_now = 7'd127;

    dlp_pkg::res_t expected_words [$];
    int   err_count  = 0;
    int   cycle_count = 0;
    int   items_sent = 0;

    // Sender pacing: bursts of random length, gaps between them.
    bit   bursty     = 1'b1;
    int   burst_left = 0;

    // Response under construction, one byte per entry.
    logic [7:0] resp_q [$];

    function automatic void clear_list_state();
        rx_offset    = '0;
        rx_phase     = PH_HEADER;
        field_acc    = '0;
        acc_bytes    = '0;
        list_count   = '0;
        entry_no     = '0;
        entry_found  = '0;
        entry_ids[0] = '0;
        entry_ids[1] = '0;
        entry_ids[2] = '0;
        entry_len    = '0;
        name_left    = '0;
        list_stopped = 1'b0;
    endfunction

    // Fields that carry no meaning for a kind stay zero.
    function automatic dlp_pkg::res_t make_word(input dlp_pkg::kind_t k,
                                                input logic [7:0] ch);
        dlp_pkg::res_t w;
        w = '0;
        w.kind = k;
        if (k != dlp_pkg::KIND_ERROR) begin
            w.entry_index = entry_no[2:0];
            w.entry_count = list_count;
        end
        if (k == dlp_pkg::KIND_ENTRY || k == dlp_pkg::KIND_NAME) begin
            w.found_flag  = entry_found;
            w.first_id    = entry_ids[0];
            w.second_id   = entry_ids[1];
            w.third_id    = entry_ids[2];
            w.name_length = entry_len;
        end
        if (k == dlp_pkg::KIND_NAME) begin
            w.name_char = ch;
        end
        return w;
    endfunction

    function automatic void next_entry();
        entry_no = entry_no + 4'd1;
        rx_phase = PH_START;
    endfunction

    // Works out the words that one accepted byte causes and queues them.
    function automatic void parse_response_byte(input logic [7:0] b,
                                                input logic [13:0] len_in,
                                                input logic last);
        logic [13:0]   len;
        logic [31:0]   shifted;
        logic [31:0]   clamped;
        dlp_pkg::res_t words [2];
        int            n;
        n = 0;
        len = (len_in > dlp_pkg::MAX_RESPONSE) ? dlp_pkg::MAX_RESPONSE : len_in;
        shifted = {field_acc[23:0], b};
        // Bytes beyond the stated length, or after a stop, only count for last_byte.
        if (!list_stopped && rx_offset < len) begin
            case (rx_phase)
                PH_HEADER: begin
                    if (rx_offset >= 14'd27) begin
                        rx_phase  = PH_COUNT;
                        field_acc = '0;
                        acc_bytes = '0;
                    end
                end
                PH_COUNT: begin
                    field_acc = shifted;
                    if (acc_bytes == 2'd3) begin
                        acc_bytes  = '0;
                        list_count = shifted;
                        words[n]   = make_word(dlp_pkg::KIND_COUNT, 8'd0);
                        n++;
                        rx_phase   = PH_START;
                    end else begin
                        acc_bytes++;
                    end
                end
                PH_START: begin
                    // Entry starts only within count, table size and length.
                    if ({28'd0, entry_no} < list_count &&
                        entry_no < dlp_pkg::MAX_ENTRIES &&
                        32'(rx_offset) + 32'd13 < 32'(len)) begin
                        entry_found  = b;
                        entry_ids[0] = '0;
                        entry_ids[1] = '0;
                        entry_ids[2] = '0;
                        entry_len    = '0;
                        field_acc    = '0;
                        acc_bytes    = '0;
                        rx_phase     = PH_ID0;
                    end else begin
                        list_stopped = 1'b1;
                    end
                end
                PH_NAME: begin
                    words[n] = make_word(dlp_pkg::KIND_NAME, b);
                    n++;
                    name_left = name_left - 7'd1;
                    if (name_left == 7'd0) begin
                        next_entry();
                    end
                end
                default: begin
                    field_acc = shifted;
                    if (acc_bytes == 2'd3) begin
                        acc_bytes = '0;
                        case (rx_phase)
                            PH_ID0: begin
                                entry_ids[0] = shifted;
                                rx_phase     = PH_ID1;
                            end
                            PH_ID1: begin
                                entry_ids[1] = shifted;
                                rx_phase     = PH_ID2;
                            end
                            PH_ID2: begin
                                entry_ids[2] = shifted;
                                rx_phase     = PH_LEN;
                            end
                            default: begin
                                clamped = (shifted > 32'(name_limit_now)) ?
                                          32'(name_limit_now) : shifted;
                                entry_len = clamped[6:0];
                                words[n]  = make_word(dlp_pkg::KIND_ENTRY, 8'd0);
                                n++;
                                if (clamped == 32'd0) begin
                                    next_entry();
                                end else begin
                                    name_left = clamped[6:0];
                                    rx_phase  = PH_NAME;
                                end
                            end
                        endcase
                        field_acc = '0;
                    end else begin
                        acc_bytes++;
                    end
                end
            endcase
        end
        if (last) begin
            // No end marker unless the count was complete.
            words[n] = make_word((rx_phase >= PH_START) ? dlp_pkg::KIND_END
                                                        : dlp_pkg::KIND_ERROR, 8'd0);
            n++;
            clear_list_state();
        end else if (rx_offset != 14'h3fff) begin
            rx_offset = rx_offset + 14'd1;  // saturates on very long streams
        end
        if (n > 0) begin
            words[n - 1].last_result = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            expected_words.push_back(words[i]);
        end
    endfunction

    function automatic void compare_field(input string fname, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
        end
    endfunction

    function automatic void check_word();
        dlp_pkg::res_t want;
        if (expected_words.size() == 0) begin
            err_count++;
            $display("%0t: unexpected result word: expected none, actual kind %0d",
                     $time, m_kind);
        end else begin
            want = expected_words.pop_front();
            compare_field("kind",        32'(want.kind),        32'(m_kind));
            compare_field("entry_index", 32'(want.entry_index), 32'(m_entry_index));
            compare_field("entry_count", want.entry_count,      m_entry_count);
            compare_field("found_flag",  32'(want.found_flag),  32'(m_found_flag));
            compare_field("first_id",    want.first_id,         m_first_id);
            compare_field("second_id",   want.second_id,        m_second_id);
            compare_field("third_id",    want.third_id,         m_third_id);
            compare_field("name_length", 32'(want.name_length), 32'(m_name_length));
            compare_field("name_char",   32'(want.name_char),   32'(m_name_char));
            compare_field("last_result", 32'(want.last_result), 32'(m_last_result));
        end
    endfunction

    // Everything is sampled at the rising edge: result words first, then the
    // register write, then the byte taken at this edge (its words come later).
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_list_state();
            name_limit_now = 7'd127;
        end else begin
            if (m_valid && m_ready) begin
                check_word();
            end
            if (cfg_valid && cfg_ready) begin
                name_limit_now = cfg_name_limit;
            end
            if (s_valid && s_ready) begin
                parse_response_byte(s_byte_value, s_response_length, s_last_byte);
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver stalls on a rotating pattern, reloaded now and then; some
    // reloads are all ones so there are stretches without back-pressure.
    logic [23:0] stall_pattern = '1;
    int          pattern_age   = 0;

    always @(negedge aclk) begin
        if (pattern_age == 0) begin
            stall_pattern <= ($urandom_range(0, 2) == 0) ? 24'hffffff
                                                           : (24'($urandom) | 24'h1);
            pattern_age   <= 200;
        end else begin
            stall_pattern <= {stall_pattern[22:0], stall_pattern[23]};
            pattern_age   <= pattern_age - 1;
        end
        m_ready <= stall_pattern[0];
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Presents one byte and returns at the edge where it is taken; valid is
    // left high so a following byte in the same burst goes out without a bubble.
    task automatic send_byte(input logic [7:0] b, input logic [13:0] len,
                             input logic last);
        int gap;
        if (bursty && burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end else if (burst_left > 0) begin
            burst_left--;
        end
        @(negedge aclk);
        s_valid           <= 1'b1;
        s_byte_value      <= b;
        s_response_length <= len;
        s_last_byte       <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Lowers valid and waits for every outstanding word plus a short settle.
    task automatic wait_idle();
        @(negedge aclk) s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_name_limit(input logic [6:0] limit);
        wait_idle();
        @(negedge aclk);
        cfg_valid      <= 1'b1;
        cfg_name_limit <= limit;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    function automatic void put_be32(input logic [31:0] v);
        resp_q.push_back(v[31:24]);
        resp_q.push_back(v[23:16]);
        resp_q.push_back(v[15:8]);
        resp_q.push_back(v[7:0]);
    endfunction

    // Random 28-byte header followed by the entry count.
    function automatic void start_response(input logic [31:0] count);
        resp_q.delete();
        repeat (28) resp_q.push_back(8'($urandom));
        put_be32(count);
    endfunction

    // Name bytes follow the clamped length so the stream stays aligned.
    function automatic void add_entry(input logic [7:0] found, input logic [31:0] id0,
                                      input logic [31:0] id1, input logic [31:0] id2,
                                      input logic [31:0] name_len);
        int names;
        names = (name_len > 32'(name_limit_now)) ? int'(name_limit_now) : int'(name_len);
        resp_q.push_back(found);
        put_be32(id0);
        put_be32(id1);
        put_be32(id2);
        put_be32(name_len);
        repeat (names) resp_q.push_back(8'($urandom));
    endfunction

    // Sends the built response with the given length field, last on the final byte.
    task automatic send_response(input logic [13:0] len_field);
        for (int i = 0; i < resp_q.size(); i++) begin
            items_sent++;
            send_byte(resp_q[i], len_field, i == resp_q.size() - 1);
        end
    endtask

    task automatic send_exact();
        send_response(14'(resp_q.size()));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Last byte before the count is complete: error word, no end marker.
    task automatic test_short_response();
        resp_q.delete();
        resp_q.push_back(8'h00);
        send_response(14'd0);
        resp_q.delete();
        repeat (3) resp_q.push_back(8'hff);
        send_exact();
        start_response(32'd5);
        void'(resp_q.pop_back());
        send_response(14'd40);
    endtask

    // Count only, no entries: count word then end marker.
    task automatic test_empty_list();
        start_response(32'd0);
        send_exact();
    endtask

    // Field extremes, a zero-length name and a short name.
    task automatic test_entry_fields();
        start_response(32'd2);
        add_entry(8'hff, 32'hffffffff, 32'h00000000, 32'h80000001, 32'd0);
        add_entry(8'h00, 32'h12345678, 32'hffffffff, 32'h00000000, 32'd3);
        send_exact();
    endtask

    // Name length clamped at both ends of the limit range.
    task automatic test_name_clamp();
        set_name_limit(7'd0);
        start_response(32'd1);
        add_entry(8'h5a, 32'd1, 32'd2, 32'd3, 32'hffffffff);
        send_exact();
        set_name_limit(7'd5);
        start_response(32'd2);
        add_entry(8'h01, 32'd4, 32'd5, 32'd6, 32'd5);
        add_entry(8'h02, 32'd7, 32'd8, 32'd9, 32'd6);
        send_exact();
        set_name_limit(7'd127);
        start_response(32'd1);
        add_entry(8'h03, 32'hdeadbeef, 32'h0, 32'h1, 32'd200);
        send_exact();
    endtask

    // Entry refused by the length, entry cut inside its fixed bytes, name cut short.
    task automatic test_cut_off_entry();
        start_response(32'd1);
        add_entry(8'h77, 32'h11111111, 32'h22222222, 32'h33333333, 32'd10);
        send_response(14'd45);
        send_response(14'd46);
        send_response(14'd53);
    endtask

    // Table size and count both stop the walk; huge count with few entries.
    task automatic test_entry_limits();
        start_response(32'd20);
        repeat (9) add_entry(8'($urandom), $urandom, $urandom, $urandom, 32'd1);
        send_exact();
        start_response(32'd1);
        repeat (2) add_entry(8'($urandom), $urandom, $urandom, $urandom, 32'd2);
        send_exact();
        start_response(32'hffffffff);
        repeat (3) add_entry(8'($urandom), $urandom, $urandom, $urandom, 32'd0);
        send_exact();
    endtask

    // Length field above the maximum response size is taken as the maximum.
    task automatic test_length_field_extremes();
        start_response(32'd1);
        add_entry(8'h80, 32'h0f0f0f0f, 32'hf0f0f0f0, 32'haaaaaaaa, 32'd2);
        send_response(14'h3fff);
    endtask

    // Mostly well-formed lists with random content; some noise and cut responses.
    task automatic test_random();
        int          n_ent;
        logic [31:0] count;
        logic [31:0] nlen;
        logic [13:0] len_field;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0:       set_name_limit(7'd0);
                    1:       set_name_limit(7'd127);
                    default: set_name_limit(7'($urandom_range(0, 20)));
                endcase
            end
            bursty = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: begin
                    // Noise: random bytes and length field.
                    resp_q.delete();
                    repeat ($urandom_range(1, 80)) resp_q.push_back(8'($urandom));
                    len_field = ($urandom_range(0, 1) == 0) ? 14'($urandom_range(0, 16383))
                                                            : 14'(resp_q.size());
                    send_response(len_field);
                end
                default: begin
                    count = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                                        : 32'($urandom_range(0, 6));
                    n_ent = (count > 32'd9) ? $urandom_range(0, 9)
                                            : int'(count) + $urandom_range(0, 1);
                    start_response(count);
                    repeat (n_ent) begin
                        nlen = ($urandom_range(0, 7) == 0) ? 32'($urandom)
                                                           : 32'($urandom_range(0, 12));
                        add_entry(8'($urandom), $urandom, $urandom, $urandom, nlen);
                    end
                    case ($urandom_range(0, 7))
                        0: len_field = 14'($urandom_range(0, 16383));
                        1: len_field = (resp_q.size() > 20)
                                       ? 14'(resp_q.size() - $urandom_range(1, 20))
                                       : 14'd0;
                        default: len_field = 14'(resp_q.size());
                    endcase
                    send_response(len_field);
                end
            endcase
            // Now and then hold off until every word is back.
            if ($urandom_range(0, 5) == 0) begin
                wait_idle();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        set_name_limit(7'd127);
        test_short_response();
        test_empty_list();
        test_entry_fields();
        test_name_clamp();
        test_cut_off_entry();
        test_entry_limits();
        test_length_field_extremes();
        test_random();
        wait_idle();
        repeat (END_CYCLES) @(posedge aclk);
        if (err_count == 0 && expected_words.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
